@@ hw/rtl/mmis_pkg.sv @@
// ----------------------------------------------------------------------------
// mmis_pkg: shared definitions of the mini-MIPS instruction step core
// Sizes of the register file and data store, opcodes and ALU function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mmis_pkg;

  localparam int DATA_DEPTH = 256;
  localparam int NUM_REGS   = 8;
  localparam int DADDR_W    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int REG_AW     = $clog2(NUM_REGS);

  typedef enum logic [3:0] {
    OP_RTYPE = 4'd0,
    OP_J     = 4'd2,
    OP_ADDI  = 4'd4,
    OP_BEQ   = 4'd8,
    OP_LW    = 4'd11,
    OP_SW    = 4'd15
  } opcode_t;

  localparam logic [2:0] FN_ADD  = 3'd0;
  localparam logic [2:0] FN_SUB  = 3'd1;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_ZERO = 3'd7;

  // Result of one instruction as held in the output stage.
  typedef struct packed {
    logic [7:0]        next_pc;
    logic              rwe;
    logic [REG_AW-1:0] ridx;
    logic [7:0]        rval;
    logic              is_lw;
    logic              in_range;
    logic              mwe;
    logic [7:0]        maddr;
    logic [7:0]        mval;
    logic [7:0]        alu;
    logic              ovf;
    logic              illegal;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mini_mips_instruction_step_core.sv @@
// ----------------------------------------------------------------------------
// mini_mips_instruction_step_core: one mini-MIPS instruction per transfer
// Executes 16-bit instructions against an internal PC, register file and
// data store, and reports the effects of each instruction as one result.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer (in_valid high, in_stall low) delivers the instruction
// found at the current program counter. Each one produces exactly one output
// transfer, in order, carrying next_pc, the register and memory writes, the
// ALU output and the overflow and illegal opcode flags.
// An instruction is registered into the execute stage at its input transfer
// and then into the output stage, where it is offered on the output. While
// out_stall is low the core takes one instruction per cycle: the register file
// is read at the input transfer, the ALU, branch and data store access happen
// in the execute stage, and the register file is written back on retirement.
// Results still in flight are forwarded to the execute stage, so dependent
// instructions follow each other without bubbles.
// When the receiver holds out_stall, the output stage keeps its result, the
// execute stage holds its instruction and in_stall rises once that stage is
// occupied; nothing is lost or repeated.
// Reset (rst, synchronous) clears the PC and marks every register as
// unwritten, so registers read as zero until written. After reset the core
// clears all DATA_DEPTH (256) data store entries, one entry per cycle, and
// in_stall stays high until that pass ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_mips_instruction_step_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [15:0]        instr_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [7:0]         next_pc,
  output      logic               reg_write_en,
  output      logic [2:0]         reg_index,
  output      logic signed [7:0]  reg_value,
  output      logic               mem_write_en,
  output      logic [7:0]         mem_addr,
  output      logic signed [7:0]  mem_value,
  output      logic signed [7:0]  alu_result,
  output      logic               alu_overflow,
  output      logic               illegal_op
);
  import mmis_pkg::*;

  // Pipeline control.
  logic        s1_valid;
  logic [15:0] s1_instr;
  logic        s2_valid;
  result_t     s2;
  logic        advance;
  logic        in_xfer;
  logic        retire;

  logic [7:0]  pc;

  // Register file: synchronous memory with two read ports and valid bits.
  logic [7:0]        rf_mem [NUM_REGS];
  logic              rf_vld [NUM_REGS];
  logic [7:0]        rf_qa;
  logic [7:0]        rf_qb;
  logic              rf_va;
  logic              rf_vb;

  // Data store: synchronous memory, one access per cycle, cleared after reset.
  logic [7:0]         dm_mem [DATA_DEPTH];
  logic [7:0]         dm_q;
  logic               clr_busy;
  logic [DADDR_W-1:0] clr_addr;

  // Write captured at the input transfer that the register read missed.
  logic              fw_we;
  logic [REG_AW-1:0] fw_idx;
  logic [7:0]        fw_val;

  logic [7:0]  wb_val;

  // Execute stage signals.
  logic [3:0]        op;
  logic [REG_AW-1:0] rs;
  logic [REG_AW-1:0] rt;
  logic [REG_AW-1:0] rd;
  logic [2:0]        funct;
  logic [7:0]        immv;
  logic [7:0]        opa;
  logic [7:0]        opb;
  logic [7:0]        alu_b;
  logic [2:0]        alu_sel;
  logic [7:0]        alu_r;
  logic              alu_v;
  logic [7:0]        pc1;
  logic [DADDR_W-1:0] dm_idx;
  result_t           s1_res;

  assign advance  = !s2_valid || !out_stall;
  assign in_stall = clr_busy || (s1_valid && !advance);
  assign in_xfer  = in_valid && !in_stall;
  assign retire   = advance && s2_valid;

  // Load results come straight from the data store read register.
  always_comb begin
    if (s2.is_lw) begin
      wb_val = s2.in_range ? dm_q : 8'd0;
    end else begin
      wb_val = s2.rval;
    end
  end

  // Field decode of the instruction in the execute stage.
  assign op    = s1_instr[15:12];
  assign rs    = s1_instr[9 +: REG_AW];
  assign rt    = s1_instr[6 +: REG_AW];
  assign rd    = s1_instr[3 +: REG_AW];
  assign funct = s1_instr[2:0];
  assign immv  = {{2{s1_instr[5]}}, s1_instr[5:0]};
  assign pc1   = pc + 8'd1;

  // Operand forwarding: output stage first, then the write that retired at
  // the input transfer, then the register file read data.
  always_comb begin
    if (s2_valid && s2.rwe && s2.ridx == rs) begin
      opa = wb_val;
    end else if (fw_we && fw_idx == rs) begin
      opa = fw_val;
    end else begin
      opa = rf_va ? rf_qa : 8'd0;
    end
    if (s2_valid && s2.rwe && s2.ridx == rt) begin
      opb = wb_val;
    end else if (fw_we && fw_idx == rt) begin
      opb = fw_val;
    end else begin
      opb = rf_vb ? rf_qb : 8'd0;
    end
  end

  // ALU operand and function selection.
  always_comb begin
    alu_b   = opb;
    alu_sel = FN_ADD;
    case (op)
      OP_RTYPE: alu_sel = funct;
      OP_BEQ:   alu_sel = FN_SUB;
      OP_ADDI, OP_LW, OP_SW: alu_b = immv;
      default: ;
    endcase
  end

  always_comb begin
    alu_v = 1'b0;
    case (alu_sel)
      FN_SUB: begin
        alu_r = opa - alu_b;
        alu_v = (opa[7] != alu_b[7]) && (alu_r[7] != opa[7]);
      end
      FN_AND:  alu_r = opa & alu_b;
      FN_OR:   alu_r = opa | alu_b;
      FN_ZERO: alu_r = 8'd0;
      default: begin
        alu_r = opa + alu_b;
        alu_v = (opa[7] == alu_b[7]) && (alu_r[7] != opa[7]);
      end
    endcase
  end

  assign dm_idx = alu_r[DADDR_W-1:0];

  // Result of the instruction in the execute stage.
  always_comb begin
    s1_res          = '0;
    s1_res.next_pc  = pc1;
    s1_res.alu      = alu_r;
    s1_res.ovf      = alu_v;
    s1_res.in_range = ({1'b0, alu_r} < 9'(DATA_DEPTH));
    case (op)
      OP_RTYPE: begin
        s1_res.rwe  = 1'b1;
        s1_res.ridx = rd;
        s1_res.rval = alu_r;
      end
      OP_J: s1_res.next_pc = s1_instr[7:0];
      OP_ADDI: begin
        s1_res.rwe  = 1'b1;
        s1_res.ridx = rt;
        s1_res.rval = alu_r;
      end
      OP_BEQ: begin
        if (alu_r == 8'd0) begin
          s1_res.next_pc = pc1 + immv;
        end
      end
      OP_LW: begin
        s1_res.rwe   = 1'b1;
        s1_res.ridx  = rt;
        s1_res.is_lw = 1'b1;
        s1_res.maddr = alu_r;
      end
      OP_SW: begin
        s1_res.maddr = alu_r;
        s1_res.mval  = opb;
        s1_res.mwe   = s1_res.in_range;
      end
      default: begin
        s1_res.alu     = 8'd0;
        s1_res.ovf     = 1'b0;
        s1_res.illegal = 1'b1;
      end
    endcase
  end

  // Pipeline control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pc       <= 8'd0;
      fw_we    <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
        fw_we    <= retire && s2.rwe;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        s2_valid <= s1_valid;
        if (s1_valid) begin
          pc <= s1_res.next_pc;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr <= instr_word;
      fw_idx   <= s2.ridx;
      fw_val   <= wb_val;
    end
    if (advance && s1_valid) begin
      s2 <= s1_res;
    end
  end

  // Register file: written when a result retires, read at the input transfer.
  always_ff @(posedge clk) begin
    if (retire && s2.rwe) begin
      rf_mem[s2.ridx] <= wb_val;
    end
    if (in_xfer) begin
      rf_qa <= rf_mem[instr_word[9 +: REG_AW]];
      rf_qb <= rf_mem[instr_word[6 +: REG_AW]];
      rf_va <= rf_vld[instr_word[9 +: REG_AW]];
      rf_vb <= rf_vld[instr_word[6 +: REG_AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_vld[i] <= 1'b0;
      end
    end else if (retire && s2.rwe) begin
      rf_vld[s2.ridx] <= 1'b1;
    end
  end

  // Clearing pass: walks every data store entry once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + DADDR_W'(1);
      if (clr_addr == DADDR_W'(DATA_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Data store: cleared entry by entry after reset, then accessed when the
  // execute stage hands over its instruction.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      dm_mem[clr_addr] <= 8'd0;
    end else if (advance && s1_valid && s1_res.mwe) begin
      dm_mem[dm_idx] <= opb;
    end
    if (advance && s1_valid && s1_res.is_lw) begin
      dm_q <= dm_mem[dm_idx];
    end
  end

  // Output channel.
  assign out_valid    = s2_valid;
  assign next_pc      = s2.next_pc;
  assign reg_write_en = s2.rwe;
  assign reg_index    = 3'(s2.ridx);
  assign reg_value    = wb_val;
  assign mem_write_en = s2.mwe;
  assign mem_addr     = s2.maddr;
  assign mem_value    = s2.mval;
  assign alu_result   = s2.alu;
  assign alu_overflow = s2.ovf;
  assign illegal_op   = s2.illegal;

endmodule

`default_nettype wire

@@ hw/rtl/mmis_checker.sv @@
// ----------------------------------------------------------------------------
// mmis_checker: port-level checks of the instruction step core
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module mmis_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] next_pc,
  input wire logic [7:0] alu_result,
  input wire logic       reg_write_en,
  input wire logic       mem_write_en,
  input wire logic       illegal_op
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its next_pc and ALU result.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(next_pc) && $stable(alu_result))
    else $error("result payload changed while stalled");

  // After reset the pipeline is empty and the input waits for the data
  // store clearing pass.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("pipeline not empty or input open after reset");

  // An undefined opcode writes neither the registers nor the data store.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal_op |-> !reg_write_en && !mem_write_en)
    else $error("undefined opcode caused a write");

endmodule

bind mini_mips_instruction_step_core mmis_checker u_mmis_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .next_pc      (next_pc),
  .alu_result   (alu_result),
  .reg_write_en (reg_write_en),
  .mem_write_en (mem_write_en),
  .illegal_op   (illegal_op)
);

`default_nettype wire

@@ tb/mmis_step_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmis_step_checker: result checker of the mini-MIPS instruction step core
// Watches both channels, executes every accepted instruction on its own copy
// of the PC, register file and data store, and compares each result transfer
// against the oldest predicted effect.
// ----------------------------------------------------------------------------

module mmis_step_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [15:0]       instr_word,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [7:0]        next_pc,
  input  wire logic              reg_write_en,
  input  wire logic [2:0]        reg_index,
  input  wire logic signed [7:0] reg_value,
  input  wire logic              mem_write_en,
  input  wire logic [7:0]        mem_addr,
  input  wire logic signed [7:0] mem_value,
  input  wire logic signed [7:0] alu_result,
  input  wire logic              alu_overflow,
  input  wire logic              illegal_op,
  output int                     fail_count,
  output int                     pending
);
  import mmis_pkg::*;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       reg_we;
    logic [2:0] reg_idx;
    logic [7:0] reg_val;
    logic       mem_we;
    logic [7:0] mem_addr;
    logic [7:0] mem_val;
    logic [7:0] alu_out;
    logic       alu_ovf;
    logic       illegal;
  } instr_effect_t;

  logic [7:0]    arch_pc;
  logic [7:0]    arch_regs [NUM_REGS];
  logic [7:0]    arch_store [DATA_DEPTH];
  instr_effect_t pending_effects [$];
  int            mismatches = 0;
  int            result_count = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // 8-bit ALU; the overflow flag only applies to add and subtract.
  function automatic void alu_eval(input logic [7:0] a, input logic [7:0] b,
                                   input logic [2:0] fn, output logic [7:0] y,
                                   output logic v);
    y = '0;
    v = 1'b0;
    case (fn)
      FN_SUB: begin
        y = a - b;
        v = (a[7] != b[7]) && (y[7] != a[7]);
      end
      FN_AND:  y = a & b;
      FN_OR:   y = a | b;
      FN_ZERO: y = '0;
      default: begin
        y = a + b;
        v = (a[7] == b[7]) && (y[7] != a[7]);
      end
    endcase
  endfunction

  // Executes one instruction on the architectural state and returns its effect.
  function automatic instr_effect_t execute_instr(input logic [15:0] w);
    instr_effect_t r;
    logic [3:0]    opc;
    logic [2:0]    rs, rt, rd;
    logic [7:0]    imm, a, b, pc_inc, y;
    logic          v;
    opc    = w[15:12];
    rs     = w[11:9];
    rt     = w[8:6];
    rd     = w[5:3];
    imm    = {{2{w[5]}}, w[5:0]};
    a      = arch_regs[rs];
    b      = arch_regs[rt];
    pc_inc = arch_pc + 8'd1;
    r      = '0;
    r.next_pc = pc_inc;
    case (opc)
      OP_RTYPE: begin
        alu_eval(a, b, w[2:0], y, v);
        r.reg_we  = 1'b1;
        r.reg_idx = rd;
        r.reg_val = y;
      end
      OP_J: begin
        alu_eval(a, b, FN_ADD, y, v);
        r.next_pc = w[7:0];
      end
      OP_ADDI: begin
        alu_eval(a, imm, FN_ADD, y, v);
        r.reg_we  = 1'b1;
        r.reg_idx = rt;
        r.reg_val = y;
      end
      OP_BEQ: begin
        alu_eval(a, b, FN_SUB, y, v);
        if (y == 8'd0) r.next_pc = pc_inc + imm;
      end
      OP_LW: begin
        alu_eval(a, imm, FN_ADD, y, v);
        r.mem_addr = y;
        r.reg_we   = 1'b1;
        r.reg_idx  = rt;
        r.reg_val  = (int'(y) < DATA_DEPTH) ? arch_store[y] : 8'd0;
      end
      OP_SW: begin
        alu_eval(a, imm, FN_ADD, y, v);
        r.mem_addr = y;
        r.mem_val  = b;
        if (int'(y) < DATA_DEPTH) begin
          arch_store[y] = b;
          r.mem_we      = 1'b1;
        end
      end
      default: begin
        y = '0;
        v = 1'b0;
        r.illegal = 1'b1;
      end
    endcase
    r.alu_out = y;
    r.alu_ovf = v;
    if (r.reg_we) arch_regs[r.reg_idx] = r.reg_val;
    arch_pc = r.next_pc;
    return r;
  endfunction

  always @(posedge clk) begin
    instr_effect_t want, seen;
    seen = '{next_pc: next_pc, reg_we: reg_write_en, reg_idx: reg_index,
             reg_val: reg_value, mem_we: mem_write_en, mem_addr: mem_addr,
             mem_val: mem_value, alu_out: alu_result, alu_ovf: alu_overflow,
             illegal: illegal_op};
    if (rst) begin
      arch_pc = '0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (arch_store[i]) arch_store[i] = '0;
      pending_effects.delete();
    end else begin
      // The result side is checked first; an instruction accepted at this edge must
      // still pass the core's registered stages, so it is never the one leaving now.
      if (out_valid && !out_stall) begin
        result_count++;
        if (pending_effects.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result %0d arrived with nothing outstanding",
                     $realtime, result_count);
        end else begin
          want = pending_effects.pop_front();
          if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, result_count);
              $display({"  expected pc=%h rwe=%b ridx=%0d rval=%h mwe=%b",
                        " maddr=%h mval=%h alu=%h ovf=%b ill=%b"},
                       want.next_pc, want.reg_we, want.reg_idx, want.reg_val,
                       want.mem_we, want.mem_addr, want.mem_val, want.alu_out,
                       want.alu_ovf, want.illegal);
              $display({"  actual   pc=%h rwe=%b ridx=%0d rval=%h mwe=%b",
                        " maddr=%h mval=%h alu=%h ovf=%b ill=%b"},
                       seen.next_pc, seen.reg_we, seen.reg_idx, seen.reg_val,
                       seen.mem_we, seen.mem_addr, seen.mem_val, seen.alu_out,
                       seen.alu_ovf, seen.illegal);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_effects.push_back(execute_instr(instr_word));
      end
    end
    fail_count <= mismatches;
    pending    <= pending_effects.size();
  end

endmodule

@@ tb/mini_mips_instruction_step_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_mips_instruction_step_core_tb: testbench of the mini-MIPS step core
// Feeds a directed instruction sequence followed by a weighted random
// program through the input channel in bursts, stalls the result channel on
// its own schedule, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------

module mini_mips_instruction_step_core_tb;
  import mmis_pkg::*;

  // Every input of the core holds a known value from time zero on.
  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic [15:0]       instr_word = '0;
  logic              out_stall  = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [7:0]        next_pc;
  logic              reg_write_en;
  logic [2:0]        reg_index;
  logic signed [7:0] reg_value;
  logic              mem_write_en;
  logic [7:0]        mem_addr;
  logic signed [7:0] mem_value;
  logic signed [7:0] alu_result;
  logic              alu_overflow;
  logic              illegal_op;
  int                fail_count;
  int                pending;

  // The whole instruction stream, directed part first.
  logic [15:0]       program_q [$];

  // Patterns of the result side; each one holds for a segment of cycles.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_RARE,
    STALL_HOLD
  } stall_mode_t;

  localparam int RANDOM_ITEMS = 1925;
  localparam int SEGMENT_LEN  = 150;
  localparam int HOLD_CYCLES  = 80;

  mini_mips_instruction_step_core dut (.*);

  // The checker predicts every accepted instruction and counts failures.
  mmis_step_checker step_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Instruction encoders; the field layout is opcode, rs, rt, rd, funct or
  // opcode, rs, rt, imm6, and a jump carries its target in the low byte.
  function automatic logic [15:0] enc_r(input logic [2:0] rs, input logic [2:0] rt,
                                        input logic [2:0] rd, input logic [2:0] fn);
    return {OP_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] enc_i(input logic [3:0] opc, input logic [2:0] rs,
                                        input logic [2:0] rt, input logic [5:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [15:0] enc_j(input logic [3:0] hi, input logic [7:0] target);
    return {OP_J, hi, target};
  endfunction

  // Random instructions lean on the legal opcodes so that the register file
  // and data store fill up with varied values; the remaining share is noise
  // from the undefined opcodes. The low twelve bits are fully random, so
  // every register number, funct code, immediate and target shows up.
  function automatic logic [15:0] random_instr();
    int         pick;
    logic [3:0] opc;
    logic [11:0] body;
    pick = $urandom_range(0, 99);
    body = 12'($urandom);
    if (pick < 22) opc = OP_RTYPE;
    else if (pick < 40) opc = OP_ADDI;
    else if (pick < 52) opc = OP_SW;
    else if (pick < 64) opc = OP_LW;
    else if (pick < 76) opc = OP_BEQ;
    else if (pick < 84) opc = OP_J;
    else begin
      opc = 4'($urandom);
      while (opc inside {OP_RTYPE, OP_J, OP_ADDI, OP_BEQ, OP_LW, OP_SW})
        opc = 4'($urandom);
    end
    return {opc, body};
  endfunction

  // Stimulus: reset, then the program in bursts of random length with gaps.
  initial begin
    int n_burst;
    int n_gap;
    int idx;

    // Immediate extremes: r1 = 31 (largest), r2 = -32 (smallest).
    program_q.push_back(enc_i(OP_ADDI, 3'd0, 3'd1, 6'd31));
    program_q.push_back(enc_i(OP_ADDI, 3'd0, 3'd2, 6'h20));
    program_q.push_back(enc_i(OP_ADDI, 3'd1, 3'd3, 6'd31));
    // 62 + 62 = 124, then 124 + 124 overflows, and -32 - 124 overflows too.
    program_q.push_back(enc_r(3'd3, 3'd3, 3'd4, FN_ADD));
    program_q.push_back(enc_r(3'd4, 3'd4, 3'd5, FN_ADD));
    program_q.push_back(enc_r(3'd2, 3'd4, 3'd6, FN_SUB));
    // Logic functions, the zero function, and unused funct codes that add.
    program_q.push_back(enc_r(3'd5, 3'd1, 3'd7, FN_AND));
    program_q.push_back(enc_r(3'd5, 3'd2, 3'd7, FN_OR));
    program_q.push_back(enc_r(3'd5, 3'd5, 3'd7, FN_ZERO));
    program_q.push_back(enc_r(3'd1, 3'd2, 3'd3, 3'd2));
    program_q.push_back(enc_r(3'd1, 3'd2, 3'd3, 3'd3));
    program_q.push_back(enc_r(3'd1, 3'd2, 3'd3, 3'd6));
    // Stores whose address wraps below zero and whose address add overflows.
    program_q.push_back(enc_i(OP_SW, 3'd0, 3'd5, 6'h20));
    program_q.push_back(enc_i(OP_SW, 3'd4, 3'd6, 6'd31));
    // Loads back from both, then from a location that was never written.
    program_q.push_back(enc_i(OP_LW, 3'd0, 3'd1, 6'h20));
    program_q.push_back(enc_i(OP_LW, 3'd4, 3'd0, 6'd31));
    program_q.push_back(enc_i(OP_LW, 3'd7, 3'd2, 6'd1));
    // A taken branch backward past address zero and one that is not taken.
    program_q.push_back(enc_i(OP_BEQ, 3'd0, 3'd0, 6'h20));
    program_q.push_back(enc_i(OP_BEQ, 3'd1, 3'd2, 6'd5));
    // Jump to the top address, where the next PC wraps to zero before the
    // branch offset is added; then jump back to zero.
    program_q.push_back(enc_j(4'hF, 8'hFF));
    program_q.push_back(enc_i(OP_BEQ, 3'd3, 3'd3, 6'd31));
    program_q.push_back(enc_j(4'h0, 8'h00));
    // Undefined opcodes, and the all-zero and all-one instruction words.
    program_q.push_back({4'd1, 12'hABC});
    program_q.push_back({4'd14, 12'h000});
    program_q.push_back({4'd3, 12'hFFF});
    program_q.push_back(16'h0000);
    program_q.push_back(16'hFFFF);

    repeat (RANDOM_ITEMS) program_q.push_back(random_instr());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < program_q.size()) begin
      n_burst = $urandom_range(1, 20);
      while (n_burst > 0 && idx < program_q.size()) begin
        // The word stays put until the core takes it.
        in_valid   <= 1'b1;
        instr_word <= program_q[idx];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        n_burst--;
      end
      // About a quarter of the bursts run straight into the next one.
      n_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (n_gap > 0) begin
        in_valid <= 1'b0;
        repeat (n_gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // The checker's counts are registered, so look at them only after the next edge.
    do @(posedge clk); while (pending != 0);
    // A further wait catches any result the core sends beyond the last one.
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("** mini_mips_instruction_step_core: PASSED **");
    else
      $display("** mini_mips_instruction_step_core: FAILED **");
    $finish;
  end

  // Result side: each segment picks a stall pattern. Two segments open with a
  // long hold-off while the sender keeps going, so the core's stages fill and
  // in_stall has to rise.
  initial begin
    int          seg;
    int          tick;
    stall_mode_t mode;
    seg = 0;
    wait (rst == 1'b0);
    forever begin
      mode = (seg == 2 || seg == 9) ? STALL_HOLD : stall_mode_t'(seg % 5);
      for (tick = 0; tick < SEGMENT_LEN; tick++) begin
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 70);
          STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
          STALL_RARE:     out_stall <= ($urandom_range(0, 99) < 10);
          default:        out_stall <= (tick < HOLD_CYCLES);
        endcase
        @(posedge clk);
      end
      seg++;
    end
  end

  // Watchdog: a correct run needs a small fraction of this time.
  initial begin
    #(5_000_000);
    $display("** mini_mips_instruction_step_core: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mmis_pkg.sv
hw/rtl/mini_mips_instruction_step_core.sv
hw/rtl/mmis_checker.sv
tb/mmis_step_checker.sv
tb/mini_mips_instruction_step_core_tb.sv
